@@ src/stlb_pkg.sv @@
// shared constants and types for the segment translate and tlb fill block
`default_nettype none
package stlb_pkg;

    localparam int TLB_SLOTS   = 64;
    localparam int STACK_PAGES = 18;
    localparam int SLOT_W      = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;

    localparam int PAGE_W     = 20;
    localparam int ADDR_W     = 32;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 6;
    localparam int CFG_IDX_W  = 3;

    localparam logic [PAGE_W-1:0] USER_TOP_PAGE = 20'h80000;
    localparam logic [PAGE_W-1:0] STACK_BASE    = USER_TOP_PAGE - PAGE_W'(STACK_PAGES);

    // fault kinds
    localparam logic [KIND_W-1:0] KIND_READ      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ_ONLY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FILLED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_KIND  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ_ONLY = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_R1_VPAGE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R1_PPAGE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R1_PAGES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R2_VPAGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R2_PPAGE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_R2_PAGES    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_PPAGE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_READY = 3'd7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
    } stlb_cmd_t;

endpackage
`default_nettype wire

@@ src/stlb_ctrl.sv @@
// controller: sequences capture, evaluation and result hand-off
`default_nettype none
module stlb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output stlb_pkg::stlb_cmd_t    cmd
);
    import stlb_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.load   = 1'b0;
        cmd.eval   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ src/stlb_datapath.sv @@
// datapath: config registers, region match, slot valid bits and free-slot search
`default_nettype none
module stlb_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire stlb_pkg::stlb_cmd_t               cmd,
    input  wire logic                              cfg_we,
    input  wire logic [stlb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [stlb_pkg::PAGE_W-1:0]       cfg_data,
    input  wire logic [stlb_pkg::KIND_W-1:0]       s_fault_kind,
    input  wire logic [stlb_pkg::ADDR_W-1:0]       s_fault_address,
    output logic [stlb_pkg::STATUS_W-1:0]          m_status,
    output logic [stlb_pkg::SLOT_OUT_W-1:0]        m_slot_index,
    output logic [stlb_pkg::PAGE_W-1:0]            m_entry_vpage,
    output logic [stlb_pkg::PAGE_W-1:0]            m_entry_ppage
);
    import stlb_pkg::*;

    logic [PAGE_W-1:0] r1_vpage_reg, r1_ppage_reg, r1_pages_reg;
    logic [PAGE_W-1:0] r2_vpage_reg, r2_ppage_reg, r2_pages_reg;
    logic [PAGE_W-1:0] stack_ppage_reg;
    logic              space_ready_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [PAGE_W-1:0] page_reg;

    logic [TLB_SLOTS-1:0] slot_valid_reg, slot_valid_next;

    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [SLOT_OUT_W-1:0] slot_out_reg, slot_out_next;
    logic [PAGE_W-1:0]     vpage_reg, vpage_next;
    logic [PAGE_W-1:0]     ppage_reg, ppage_next;

    logic [PAGE_W:0]     r1_end, r2_end;
    logic                hit1, hit2, hit_stack, mapped;
    logic [PAGE_W-1:0]   xlat_ppage;
    logic                free_found;
    logic [SLOT_W-1:0]   free_slot;
    logic [SLOT_W+SLOT_OUT_W-1:0] free_slot_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_vpage_reg    <= '0;
            r1_ppage_reg    <= '0;
            r1_pages_reg    <= '0;
            r2_vpage_reg    <= '0;
            r2_ppage_reg    <= '0;
            r2_pages_reg    <= '0;
            stack_ppage_reg <= '0;
            space_ready_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_R1_VPAGE:    r1_vpage_reg    <= cfg_data;
                REG_R1_PPAGE:    r1_ppage_reg    <= cfg_data;
                REG_R1_PAGES:    r1_pages_reg    <= cfg_data;
                REG_R2_VPAGE:    r2_vpage_reg    <= cfg_data;
                REG_R2_PPAGE:    r2_ppage_reg    <= cfg_data;
                REG_R2_PAGES:    r2_pages_reg    <= cfg_data;
                REG_STACK_PPAGE: stack_ppage_reg <= cfg_data;
                REG_SPACE_READY: space_ready_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // captured fault word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_fault_kind;
            page_reg <= s_fault_address[ADDR_W-1 -: PAGE_W];
        end
    end

    // segment ends carry one extra bit so they never wrap
    always_comb begin
        r1_end    = {1'b0, r1_vpage_reg} + {1'b0, r1_pages_reg};
        r2_end    = {1'b0, r2_vpage_reg} + {1'b0, r2_pages_reg};
        hit1      = (page_reg >= r1_vpage_reg) && ({1'b0, page_reg} < r1_end);
        hit2      = (page_reg >= r2_vpage_reg) && ({1'b0, page_reg} < r2_end);
        hit_stack = (page_reg >= STACK_BASE) && (page_reg < USER_TOP_PAGE);
        mapped    = hit1 || hit2 || hit_stack;
        if (hit1) begin
            xlat_ppage = page_reg - r1_vpage_reg + r1_ppage_reg;
        end else if (hit2) begin
            xlat_ppage = page_reg - r2_vpage_reg + r2_ppage_reg;
        end else begin
            xlat_ppage = page_reg - STACK_BASE + stack_ppage_reg;
        end
    end

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = TLB_SLOTS - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
        free_slot_wide = {{SLOT_OUT_W{1'b0}}, free_slot};
    end

    always_comb begin
        slot_valid_next = slot_valid_reg;
        status_next     = ST_FILLED;
        slot_out_next   = '0;
        vpage_next      = '0;
        ppage_next      = '0;
        if (kind_reg == KIND_READ_ONLY) begin
            status_next = ST_READ_ONLY;
        end else if (kind_reg == KIND_OTHER) begin
            status_next = ST_BAD_KIND;
        end else if (!space_ready_reg) begin
            status_next = ST_NO_SPACE;
        end else if (!mapped) begin
            status_next = ST_UNMAPPED;
        end else if (!free_found) begin
            status_next = ST_FULL;
        end else begin
            slot_valid_next[free_slot] = 1'b1;
            slot_out_next = free_slot_wide[SLOT_OUT_W-1:0];
            vpage_next    = page_reg;
            ppage_next    = xlat_ppage;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
        end else if (cmd.eval) begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            status_reg   <= status_next;
            slot_out_reg <= slot_out_next;
            vpage_reg    <= vpage_next;
            ppage_reg    <= ppage_next;
        end
    end

    assign m_status      = status_reg;
    assign m_slot_index  = slot_out_reg;
    assign m_entry_vpage = vpage_reg;
    assign m_entry_ppage = ppage_reg;

endmodule
`default_nettype wire

@@ src/segment_translate_tlb_fill.sv @@
// top level: page fault translation through two segments and a stack region with tlb refill
`default_nettype none
// Each fault word (kind and address) is taken when s_ready is high, evaluated in the
// following cycle and shown on the m_ side in the cycle after that, held there until m_ready
// is high, stalling while m_ready stays low; the block holds one word at a time,
// set by the controller's idle, evaluate and result states. Kind is checked first, then
// space_ready, then segment 1, segment 2 and the stack region, then a free slot. A filled
// word marks the lowest free slot valid and reports it with the virtual and physical
// pages; slots are freed only by reset. On any other status the slot and page fields are
// zero. Configuration writes are always taken (cfg_ready is tied high) and should come
// only while no word is in flight.
module segment_translate_tlb_fill (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [stlb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [stlb_pkg::PAGE_W-1:0]       cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [stlb_pkg::KIND_W-1:0]       s_fault_kind,
    input  wire logic [stlb_pkg::ADDR_W-1:0]       s_fault_address,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [stlb_pkg::STATUS_W-1:0]          m_status,
    output logic [stlb_pkg::SLOT_OUT_W-1:0]        m_slot_index,
    output logic [stlb_pkg::PAGE_W-1:0]            m_entry_vpage,
    output logic [stlb_pkg::PAGE_W-1:0]            m_entry_ppage
);
    import stlb_pkg::*;

    stlb_cmd_t cmd;

    assign cfg_ready = 1'b1;

    stlb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    stlb_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_fault_kind    (s_fault_kind),
        .s_fault_address (s_fault_address),
        .m_status        (m_status),
        .m_slot_index    (m_slot_index),
        .m_entry_vpage   (m_entry_vpage),
        .m_entry_ppage   (m_entry_ppage)
    );

    // one word in flight: no new word while a result waits
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a result is pending");

    // a word passes through the evaluate state before its result shows
    a_eval_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!m_valid && !s_ready))
        else $error("result shown without an evaluate cycle");

    // failed lookups carry zeroed entry fields
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_FILLED)) |->
            (m_slot_index == '0 && m_entry_vpage == '0 && m_entry_ppage == '0))
        else $error("non-zero entry on a failed word");

endmodule
`default_nettype wire
